>>> hw/rtl/pdc_pkg.sv
// shared types and constants of the pwm duty capture block
// no dependencies; imported by every module of the block

package pdc_pkg;

   localparam int TIME_BITS_DEFAULT = 32;  // width of the internal time arithmetic
   localparam int STAMP_W           = 32;  // width of the timestamp field
   localparam int CSR_W             = 16;  // width of every configuration register
   localparam int CSR_IDX_W         = 2;
   localparam int DUTY_W            = 14;
   localparam int COUNT_W           = 32;
   localparam int PROD_W            = 30;  // high time times full scale

   localparam logic [DUTY_W-1:0] FULL_SCALE = DUTY_W'(10000);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GLITCH_REJECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PERIOD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PERIOD    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STUCK_TIMEOUT = 2'd3;

   // configuration reset values
   localparam logic [CSR_W-1:0] GLITCH_REJECT_RST = 16'd1;
   localparam logic [CSR_W-1:0] MIN_PERIOD_RST    = 16'd25;
   localparam logic [CSR_W-1:0] MAX_PERIOD_RST    = 16'd80;
   localparam logic [CSR_W-1:0] STUCK_TIMEOUT_RST = 16'd200;

   // request opcodes
   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // status codes
   localparam logic STATUS_STUCK    = 1'b0;
   localparam logic STATUS_MEASURED = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [STAMP_W-1:0] time_us;
      logic               pin_level;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]  duty;
      logic               status;
      logic [COUNT_W-1:0] rejected_count;
   } rsp_type;

endpackage

>>> hw/rtl/pdc_alu.sv
// shared subtract and compare unit of the pwm duty capture block
// depends on pdc_pkg for the default operand width

module pdc_alu
   import pdc_pkg::*;
#(
   parameter int WIDTH = PROD_W
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic [WIDTH-1:0] diff,
   output logic             borrow
);

   logic [WIDTH:0] full;

   // borrow set means op_a < op_b
   assign full   = {1'b0, op_a} - {1'b0, op_b};
   assign diff   = full[WIDTH-1:0];
   assign borrow = full[WIDTH];

endmodule

>>> hw/rtl/pwm_duty_capture_core.sv
// top level of the pwm duty capture block: sequencer, state and output register
// depends on pdc_pkg and pdc_alu

// pwm duty capture core
//
// req channel: valid/ready beats carrying an opcode, a microsecond timestamp and
// the pin level. an edge beat updates the edge tracker and gives no response; a
// query beat gives exactly one rsp beat with duty (0.01 percent units), status
// and the running reject count.
// csr port: write-only, csr_we with csr_index and csr_wdata, taken every cycle.
// timing: every edge, compare and divide step goes through one shared
// subtractor, one step per cycle, so the block works on one beat at a time and
// req_ready is low while it does.
//   edge beat: gap and glitch compare, and on closing a rise-fall-rise cycle also
//   period, high, min, max and high compare; query beat: age and timeout compare,
//   then multiply and the 14-step restoring divide unless stuck or zero-period
// rsp: a single output register; a finished query waits there while the
// receiver stalls and the core parks until that register frees up, so edge
// beats keep flowing as long as no second query is finished.
// reset: synchronous, clears the edge tracker, the good-cycle flag, the reject
// count and the rsp register, and loads the configuration defaults.

module pwm_duty_capture_core
   import pdc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // the shared unit must hold both a timestamp and the divide remainder
   localparam int ALU_W = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;
   localparam int BIT_W = $clog2(DUTY_W);

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_E_GAP  = 4'd1;   // now - last edge
   localparam logic [3:0] ST_E_GCMP = 4'd2;   // gap vs glitch window, edge decision
   localparam logic [3:0] ST_E_PER  = 4'd3;   // now - rise
   localparam logic [3:0] ST_E_HIGH = 4'd4;   // fall - rise
   localparam logic [3:0] ST_E_MIN  = 4'd5;   // period vs min
   localparam logic [3:0] ST_E_MAX  = 4'd6;   // max vs period
   localparam logic [3:0] ST_E_HCMP = 4'd7;   // period vs high, commit cycle
   localparam logic [3:0] ST_Q_AGE  = 4'd8;   // now - good time
   localparam logic [3:0] ST_Q_ACMP = 4'd9;   // timeout vs age
   localparam logic [3:0] ST_Q_MUL  = 4'd10;  // high times full scale
   localparam logic [3:0] ST_Q_DIV  = 4'd11;  // one quotient bit a cycle
   localparam logic [3:0] ST_Q_DONE = 4'd12;  // hand to the rsp register

   logic [3:0]           state_ff, state_in;

   // configuration
   logic [CSR_W-1:0]     glitch_ff, glitch_in;
   logic [CSR_W-1:0]     min_per_ff, min_per_in;
   logic [CSR_W-1:0]     max_per_ff, max_per_in;
   logic [CSR_W-1:0]     timeout_ff, timeout_in;

   // latched request
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 level_ff, level_in;

   // edge tracker
   logic [TIME_BITS-1:0] last_edge_ff, last_edge_in;
   logic                 edge_seen_ff, edge_seen_in;
   logic                 prior_level_ff, prior_level_in;
   logic [TIME_BITS-1:0] rise_time_ff, rise_time_in;
   logic                 rise_seen_ff, rise_seen_in;
   logic [TIME_BITS-1:0] fall_time_ff, fall_time_in;
   logic                 fall_after_ff, fall_after_in;
   logic [CSR_W-1:0]     good_period_ff, good_period_in;
   logic [CSR_W-1:0]     good_high_ff, good_high_in;
   logic [TIME_BITS-1:0] good_time_ff, good_time_in;
   logic                 good_seen_ff, good_seen_in;
   logic [COUNT_W-1:0]   reject_ff, reject_in;

   // working registers
   logic [TIME_BITS-1:0] gap_ff, gap_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic [TIME_BITS-1:0] high_ff, high_in;
   logic                 cyc_bad_ff, cyc_bad_in;
   logic [ALU_W-1:0]     rem_ff, rem_in;
   logic [DUTY_W-1:0]    quot_ff, quot_in;
   logic                 status_ff, status_in;
   logic [BIT_W-1:0]     bit_idx_ff, bit_idx_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // shared unit
   logic [ALU_W-1:0]     alu_a, alu_b, alu_diff;
   logic                 alu_borrow;
   logic [PROD_W-1:0]    prod;

   pdc_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   // constant multiply feeding the divider remainder
   assign prod = PROD_W'(good_high_ff) * PROD_W'(FULL_SCALE);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // operand select for the shared subtractor
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         ST_E_GAP: begin
            alu_a = ALU_W'(now_ff);
            alu_b = ALU_W'(last_edge_ff);
         end
         ST_E_GCMP: begin
            alu_a = ALU_W'(gap_ff);
            alu_b = ALU_W'(glitch_ff);
         end
         ST_E_PER: begin
            alu_a = ALU_W'(now_ff);
            alu_b = ALU_W'(rise_time_ff);
         end
         ST_E_HIGH: begin
            alu_a = ALU_W'(fall_time_ff);
            alu_b = ALU_W'(rise_time_ff);
         end
         ST_E_MIN: begin
            alu_a = ALU_W'(period_ff);
            alu_b = ALU_W'(min_per_ff);
         end
         ST_E_MAX: begin
            alu_a = ALU_W'(max_per_ff);
            alu_b = ALU_W'(period_ff);
         end
         ST_E_HCMP: begin
            alu_a = ALU_W'(period_ff);
            alu_b = ALU_W'(high_ff);
         end
         ST_Q_AGE: begin
            alu_a = ALU_W'(now_ff);
            alu_b = ALU_W'(good_time_ff);
         end
         ST_Q_ACMP: begin
            alu_a = ALU_W'(timeout_ff);
            alu_b = ALU_W'(gap_ff);
         end
         ST_Q_DIV: begin
            // trial subtract of the divisor aligned to the current quotient bit
            alu_a = rem_ff;
            alu_b = ALU_W'(good_period_ff) << bit_idx_ff;
         end
         default: begin
         end
      endcase
   end

   // sequencer and next-state logic
   always_comb begin
      state_in       = state_ff;
      glitch_in      = glitch_ff;
      min_per_in     = min_per_ff;
      max_per_in     = max_per_ff;
      timeout_in     = timeout_ff;
      now_in         = now_ff;
      level_in       = level_ff;
      last_edge_in   = last_edge_ff;
      edge_seen_in   = edge_seen_ff;
      prior_level_in = prior_level_ff;
      rise_time_in   = rise_time_ff;
      rise_seen_in   = rise_seen_ff;
      fall_time_in   = fall_time_ff;
      fall_after_in  = fall_after_ff;
      good_period_in = good_period_ff;
      good_high_in   = good_high_ff;
      good_time_in   = good_time_ff;
      good_seen_in   = good_seen_ff;
      reject_in      = reject_ff;
      gap_in         = gap_ff;
      period_in      = period_ff;
      high_in        = high_ff;
      cyc_bad_in     = cyc_bad_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      status_in      = status_ff;
      bit_idx_in     = bit_idx_ff;
      rsp_data_in    = rsp_data_ff;
      // a pending beat leaves when the receiver takes it
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         case (csr_index)
            CSR_GLITCH_REJECT: glitch_in  = csr_wdata;
            CSR_MIN_PERIOD:    min_per_in = csr_wdata;
            CSR_MAX_PERIOD:    max_per_in = csr_wdata;
            CSR_STUCK_TIMEOUT: timeout_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in   = TIME_BITS'(req_data.time_us);
               level_in = req_data.pin_level;
               state_in = (req_data.opcode == OP_QUERY) ? ST_Q_AGE : ST_E_GAP;
            end
         end
         ST_E_GAP: begin
            gap_in   = alu_diff[TIME_BITS-1:0];
            state_in = ST_E_GCMP;
         end
         ST_E_GCMP: begin
            state_in = ST_IDLE;
            if (edge_seen_ff && alu_borrow) begin
               // edge inside the glitch window
               reject_in = reject_ff + 1'b1;
            end else if (edge_seen_ff && (level_ff == prior_level_ff)) begin
               // repeated level still moves the edge time
               reject_in    = reject_ff + 1'b1;
               last_edge_in = now_ff;
            end else begin
               last_edge_in   = now_ff;
               prior_level_in = level_ff;
               edge_seen_in   = 1'b1;
               if (level_ff) begin
                  if (rise_seen_ff && fall_after_ff) begin
                     cyc_bad_in = 1'b0;
                     state_in   = ST_E_PER;
                  end else begin
                     rise_time_in  = now_ff;
                     rise_seen_in  = 1'b1;
                     fall_after_in = 1'b0;
                  end
               end else if (!rise_seen_ff) begin
                  // fall before any rise
                  reject_in = reject_ff + 1'b1;
               end else begin
                  fall_time_in  = now_ff;
                  fall_after_in = 1'b1;
               end
            end
         end
         ST_E_PER: begin
            period_in = alu_diff[TIME_BITS-1:0];
            state_in  = ST_E_HIGH;
         end
         ST_E_HIGH: begin
            high_in  = alu_diff[TIME_BITS-1:0];
            state_in = ST_E_MIN;
         end
         ST_E_MIN: begin
            cyc_bad_in = cyc_bad_ff || alu_borrow;
            state_in   = ST_E_MAX;
         end
         ST_E_MAX: begin
            cyc_bad_in = cyc_bad_ff || alu_borrow;
            state_in   = ST_E_HCMP;
         end
         ST_E_HCMP: begin
            if (cyc_bad_ff || alu_borrow) begin
               reject_in = reject_ff + 1'b1;
            end else begin
               // period is bounded by max, so both fit the register width
               good_period_in = period_ff[CSR_W-1:0];
               good_high_in   = high_ff[CSR_W-1:0];
               good_time_in   = now_ff;
               good_seen_in   = 1'b1;
            end
            rise_time_in  = now_ff;
            rise_seen_in  = 1'b1;
            fall_after_in = 1'b0;
            state_in      = ST_IDLE;
         end
         ST_Q_AGE: begin
            gap_in   = alu_diff[TIME_BITS-1:0];
            state_in = ST_Q_ACMP;
         end
         ST_Q_ACMP: begin
            if (!good_seen_ff || alu_borrow) begin
               // no fresh cycle: answer the live pin level
               quot_in   = level_ff ? FULL_SCALE : '0;
               status_in = STATUS_STUCK;
               state_in  = ST_Q_DONE;
            end else if (good_period_ff == '0) begin
               quot_in   = '0;
               status_in = STATUS_MEASURED;
               state_in  = ST_Q_DONE;
            end else begin
               status_in = STATUS_MEASURED;
               state_in  = ST_Q_MUL;
            end
         end
         ST_Q_MUL: begin
            rem_in     = ALU_W'(prod);
            quot_in    = '0;
            bit_idx_in = BIT_W'(DUTY_W - 1);
            state_in   = ST_Q_DIV;
         end
         ST_Q_DIV: begin
            if (!alu_borrow) begin
               rem_in              = alu_diff;
               quot_in[bit_idx_ff] = 1'b1;
            end
            if (bit_idx_ff == '0) begin
               state_in = ST_Q_DONE;
            end else begin
               bit_idx_in = bit_idx_ff - 1'b1;
            end
         end
         ST_Q_DONE: begin
            // park until the rsp register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.duty           = quot_ff;
               rsp_data_in.status         = status_ff;
               rsp_data_in.rejected_count = reject_ff;
               rsp_valid_in               = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         glitch_ff      <= GLITCH_REJECT_RST;
         min_per_ff     <= MIN_PERIOD_RST;
         max_per_ff     <= MAX_PERIOD_RST;
         timeout_ff     <= STUCK_TIMEOUT_RST;
         edge_seen_ff   <= 1'b0;
         prior_level_ff <= 1'b0;
         rise_seen_ff   <= 1'b0;
         fall_after_ff  <= 1'b0;
         good_seen_ff   <= 1'b0;
         reject_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         glitch_ff      <= glitch_in;
         min_per_ff     <= min_per_in;
         max_per_ff     <= max_per_in;
         timeout_ff     <= timeout_in;
         edge_seen_ff   <= edge_seen_in;
         prior_level_ff <= prior_level_in;
         rise_seen_ff   <= rise_seen_in;
         fall_after_ff  <= fall_after_in;
         good_seen_ff   <= good_seen_in;
         reject_ff      <= reject_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, only read behind the flags above
   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      level_ff       <= level_in;
      last_edge_ff   <= last_edge_in;
      rise_time_ff   <= rise_time_in;
      fall_time_ff   <= fall_time_in;
      good_period_ff <= good_period_in;
      good_high_ff   <= good_high_in;
      good_time_ff   <= good_time_in;
      gap_ff         <= gap_in;
      period_ff      <= period_in;
      high_ff        <= high_in;
      cyc_bad_ff     <= cyc_bad_in;
      rem_ff         <= rem_in;
      quot_ff        <= quot_in;
      status_ff      <= status_in;
      bit_idx_ff     <= bit_idx_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule

>>> hw/rtl/pdc_checker.sv
// port-level checks of the pwm duty capture core, with the bind that attaches them
// depends on pdc_pkg and pwm_duty_capture_core

module pdc_checker
   import pdc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // req ready drops after every accepted req beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready right after a beat");

   // a stuck answer is always the bare pin level, a measured one never over full scale
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_MEASURED && rsp_data.duty <= FULL_SCALE)
                 || rsp_data.duty == '0 || rsp_data.duty == FULL_SCALE)
      else $error("duty out of range");

endmodule

bind pwm_duty_capture_core pdc_checker u_pdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/tb_top.sv
// self-checking testbench of the pwm duty capture core: scoreboard class and top module
// depends on pdc_pkg and pwm_duty_capture_core; predicts every query answer on its own

module tb_top
   import pdc_pkg::*;
();

   class duty_scoreboard;
      // register copies
      logic [CSR_W-1:0]   glitch_gap;
      logic [CSR_W-1:0]   period_floor;
      logic [CSR_W-1:0]   period_ceil;
      logic [CSR_W-1:0]   stuck_limit;
      // edge tracker copy
      logic [STAMP_W-1:0] last_edge;
      logic               edge_seen;
      logic               prior_level;
      logic [STAMP_W-1:0] rise_at;
      logic               rise_seen;
      logic [STAMP_W-1:0] fall_at;
      logic               fall_after_rise;
      logic [15:0]        good_period;
      logic [15:0]        good_high;
      logic [STAMP_W-1:0] good_at;
      logic               good_seen;
      logic [COUNT_W-1:0] reject_total;

      rsp_type     duty_answers[$];
      int unsigned errors;
      int unsigned edges;
      int unsigned queries;
      int unsigned checked;

      function new();
         glitch_gap      = GLITCH_REJECT_RST;
         period_floor    = MIN_PERIOD_RST;
         period_ceil     = MAX_PERIOD_RST;
         stuck_limit     = STUCK_TIMEOUT_RST;
         last_edge       = '0;
         edge_seen       = 1'b0;
         prior_level     = 1'b0;
         rise_at         = '0;
         rise_seen       = 1'b0;
         fall_at         = '0;
         fall_after_rise = 1'b0;
         good_period     = '0;
         good_high       = '0;
         good_at         = '0;
         good_seen       = 1'b0;
         reject_total    = '0;
         errors          = 0;
         edges           = 0;
         queries         = 0;
         checked         = 0;
      endfunction

      function void load_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_GLITCH_REJECT: glitch_gap   = val;
            CSR_MIN_PERIOD:    period_floor = val;
            CSR_MAX_PERIOD:    period_ceil  = val;
            CSR_STUCK_TIMEOUT: stuck_limit  = val;
            default: ;
         endcase
      endfunction

      // update the tracker for an accepted beat, queue the answer of a query
      function void note_request(req_type beat);
         logic [STAMP_W-1:0] age;
         logic [STAMP_W-1:0] period;
         logic [STAMP_W-1:0] high_time;
         rsp_type            ans;
         if (beat.opcode == OP_QUERY) begin
            queries++;
            age = beat.time_us - good_at;
            ans.rejected_count = reject_total;
            if (!good_seen || age > STAMP_W'(stuck_limit)) begin
               ans.status = STATUS_STUCK;
               ans.duty   = beat.pin_level ? FULL_SCALE : '0;
            end else begin
               ans.status = STATUS_MEASURED;
               if (good_period == 0)
                  ans.duty = '0;
               else
                  ans.duty = DUTY_W'((32'(good_high) * 32'(FULL_SCALE)) / 32'(good_period));
            end
            duty_answers.push_back(ans);
            return;
         end
         edges++;
         if (edge_seen && (beat.time_us - last_edge) < STAMP_W'(glitch_gap)) begin
            reject_total++;
            return;
         end
         if (edge_seen && beat.pin_level == prior_level) begin
            reject_total++;
            last_edge = beat.time_us;
            return;
         end
         last_edge   = beat.time_us;
         prior_level = beat.pin_level;
         edge_seen   = 1'b1;
         if (beat.pin_level) begin
            if (rise_seen && fall_after_rise) begin
               period    = beat.time_us - rise_at;
               high_time = fall_at - rise_at;
               if (period >= STAMP_W'(period_floor) && period <= STAMP_W'(period_ceil) &&
                   high_time <= period) begin
                  good_period = period[15:0];
                  good_high   = high_time[15:0];
                  good_at     = beat.time_us;
                  good_seen   = 1'b1;
               end else begin
                  reject_total++;
               end
            end
            rise_at         = beat.time_us;
            rise_seen       = 1'b1;
            fall_after_rise = 1'b0;
         end else begin
            if (!rise_seen) begin
               reject_total++;
               return;
            end
            fall_at         = beat.time_us;
            fall_after_rise = 1'b1;
         end
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (duty_answers.size() == 0) begin
            report($sformatf("rsp beat with nothing expected: duty %0d status %0d rejects %0d",
                             got.duty, got.status, got.rejected_count));
            return;
         end
         want = duty_answers.pop_front();
         checked++;
         if (got.duty !== want.duty)
            report($sformatf("answer %0d duty %0d, expected %0d", checked, got.duty, want.duty));
         if (got.status !== want.status)
            report($sformatf("answer %0d status %0d, expected %0d",
                             checked, got.status, want.status));
         if (got.rejected_count !== want.rejected_count)
            report($sformatf("answer %0d reject count %0d, expected %0d",
                             checked, got.rejected_count, want.rejected_count));
      endtask

      function int unsigned pending();
         return duty_answers.size();
      endfunction
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GLITCH_REJECT;
   logic [CSR_W-1:0]     csr_wdata = '0;

   duty_scoreboard sb = new();

   // traffic shaping knobs, changed only between phases
   bit          gaps_on    = 1'b0;
   bit          stalls_on  = 1'b0;
   int unsigned burst_left = 0;
   int unsigned stall_left = 0;
   int unsigned settings   = 1;

   pwm_duty_capture_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // safety net: the slowest legal run is far shorter than this
   initial begin
      #10_000_000;
      $display("timeout: %0d answers still outstanding", sb.pending());
      $display("tb_top NOT OK");
      $finish;
   end

   // monitor: sample both handshakes with pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_data);
      end
   end

   // receiver: ready most of the time, with occasional stalls when stalls_on is set
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) < 3) begin
         stall_left <= $urandom_range(0, 39);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one req beat; called at a rising edge, returns at the edge that accepts it
   task automatic send_beat(logic op, logic [STAMP_W-1:0] stamp, logic level);
      if (gaps_on && burst_left == 0) begin
         // gap between bursts, valid drops for a random number of cycles
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left != 0)
         burst_left--;
      req_valid         <= 1'b1;
      req_data.opcode    <= op;
      req_data.time_us   <= stamp;
      req_data.pin_level <= level;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off until every answer is back, then let a trailing edge beat finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      // let the monitor log a beat taken at this edge before checking the answers
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   // write all four registers on consecutive cycles while the core is idle
   task automatic set_config(logic [CSR_W-1:0] glitch, logic [CSR_W-1:0] floor_us,
                             logic [CSR_W-1:0] ceil_us, logic [CSR_W-1:0] stuck_us);
      logic [CSR_IDX_W-1:0] order[4];
      logic [CSR_W-1:0]     vals[4];
      order = '{CSR_GLITCH_REJECT, CSR_MIN_PERIOD, CSR_MAX_PERIOD, CSR_STUCK_TIMEOUT};
      vals  = '{glitch, floor_us, ceil_us, stuck_us};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         sb.load_reg(order[i], vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings++;
   endtask

   // pwm-like traffic: mostly clean rise-fall-rise trains around the period
   // window, mixed with queries, glitches, time jumps and pure noise
   task automatic drive_pwm(int unsigned count);
      int unsigned        sent;
      int unsigned        pick;
      int                 lo_p;
      int                 hi_p;
      int unsigned        per;
      int unsigned        hi;
      logic               level_now;
      logic [STAMP_W-1:0] next_rise;
      logic [STAMP_W-1:0] next_fall;
      logic [STAMP_W-1:0] stamp;
      sent      = 0;
      level_now = 1'b0;
      next_rise = $urandom();
      next_fall = next_rise;
      stamp     = next_rise;
      lo_p      = int'(sb.period_floor) - 8;
      hi_p      = int'(sb.period_ceil) + 8;
      if (lo_p < 0)
         lo_p = 0;
      if (hi_p > 65535)
         hi_p = 65535;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // noise beat, any field value
            send_beat(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
         end else if (pick < 14) begin
            // edge close behind the last one
            send_beat(OP_EDGE, stamp + $urandom_range(0, int'(sb.glitch_gap)),
                      1'($urandom_range(0, 1)));
         end else if (pick < 17) begin
            // long silence, the train resumes much later (wraps the stamp too)
            next_rise = next_rise + $urandom();
            stamp     = next_rise;
            send_beat(OP_QUERY, stamp, 1'($urandom_range(0, 1)));
         end else if (pick < 35) begin
            send_beat(OP_QUERY, stamp + $urandom_range(0, int'(sb.stuck_limit) + 40),
                      1'($urandom_range(0, 1)));
         end else if (!level_now) begin
            per       = $urandom_range(hi_p, lo_p);
            hi        = $urandom_range(per, 0);
            stamp     = next_rise;
            next_fall = next_rise + STAMP_W'(hi);
            next_rise = next_rise + STAMP_W'(per);
            level_now = 1'b1;
            send_beat(OP_EDGE, stamp, 1'b1);
         end else begin
            stamp     = next_fall;
            level_now = 1'b0;
            send_beat(OP_EDGE, stamp, 1'b0);
         end
         sent++;
      end
   endtask

   task automatic run_phase(logic [CSR_W-1:0] glitch, logic [CSR_W-1:0] floor_us,
                            logic [CSR_W-1:0] ceil_us, logic [CSR_W-1:0] stuck_us,
                            bit gaps, bit stalls, int unsigned count);
      wait_idle();
      set_config(glitch, floor_us, ceil_us, stuck_us);
      gaps_on   = gaps;
      stalls_on = stalls;
      drive_pwm(count);
   endtask

   initial begin
      int unsigned floor_r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset defaults: glitch 1, window 25..80, timeout 200
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send_beat(OP_QUERY, 32'h0000_0000, 1'b0);   // no good cycle yet, pin low
      send_beat(OP_QUERY, 32'hFFFF_FFFF, 1'b1);   // no good cycle yet, pin high
      send_beat(OP_EDGE,  32'd10, 1'b0);          // first edge is a fall before any rise
      send_beat(OP_EDGE,  32'd20, 1'b1);          // first rise
      send_beat(OP_EDGE,  32'd20, 1'b0);          // glitch, too close
      send_beat(OP_EDGE,  32'd25, 1'b1);          // repeated level, still moves the edge time
      send_beat(OP_EDGE,  32'd50, 1'b0);          // fall, high 30
      send_beat(OP_EDGE,  32'd70, 1'b1);          // rise, period 50 kept
      send_beat(OP_QUERY, 32'd270, 1'b0);         // age exactly at the timeout
      send_beat(OP_QUERY, 32'd271, 1'b1);         // one past the timeout
      send_beat(OP_EDGE,  32'd100, 1'b0);
      send_beat(OP_EDGE,  32'd200, 1'b1);         // period too long
      send_beat(OP_EDGE,  32'd210, 1'b0);
      send_beat(OP_EDGE,  32'd215, 1'b1);         // period too short
      send_beat(OP_EDGE,  32'd300, 1'b0);
      send_beat(OP_EDGE,  32'd290, 1'b1);         // high time longer than the period
      send_beat(OP_EDGE,  32'hFFFF_FFF0, 1'b0);
      send_beat(OP_EDGE,  32'h0000_0000, 1'b1);   // huge period across the wrap
      send_beat(OP_EDGE,  32'h0000_0014, 1'b0);
      send_beat(OP_EDGE,  32'h0000_0028, 1'b1);   // period 40 from the rise at the wrap point
      send_beat(OP_QUERY, 32'h0000_0028, 1'b0);

      // zero period: no glitch gap, window 0..0, timeout 0
      wait_idle();
      set_config(16'd0, 16'd0, 16'd0, 16'd0);
      send_beat(OP_EDGE,  32'd1000, 1'b0);
      send_beat(OP_EDGE,  32'd1000, 1'b1);
      send_beat(OP_EDGE,  32'd1000, 1'b0);
      send_beat(OP_EDGE,  32'd1000, 1'b1);        // period 0 kept
      send_beat(OP_QUERY, 32'd1000, 1'b1);        // measured, duty 0
      send_beat(OP_QUERY, 32'd1001, 1'b1);        // stuck high

      // random phases; the drain before each one is a full pause of the sender
      run_phase(GLITCH_REJECT_RST, MIN_PERIOD_RST, MAX_PERIOD_RST, STUCK_TIMEOUT_RST,
                1'b0, 1'b0, 300);
      run_phase(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 300);
      run_phase(16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 1'b1, 1'b0, 300);
      run_phase(16'd2, 16'd100, 16'd50, 16'd500, 1'b0, 1'b1, 300);   // inverted window
      for (int p = 0; p < 2; p++) begin
         floor_r = $urandom_range(1, 60);
         run_phase(CSR_W'($urandom_range(0, 6)), CSR_W'(floor_r),
                   CSR_W'(floor_r + $urandom_range(0, 120)),
                   CSR_W'($urandom_range(0, 600)), 1'b1, 1'b1, 300);
      end

      wait_idle();
      if (sb.pending() != 0)
         sb.report($sformatf("%0d answers never arrived", sb.pending()));
      $display("covered %0d edge beats and %0d queries over %0d register settings",
               sb.edges, sb.queries, settings);
      $display("%0d answers checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_alu.sv
hw/rtl/pwm_duty_capture_core.sv
hw/rtl/pdc_checker.sv
tb/tb_top.sv
